// ----- rtl/btag_pkg.sv -----
// Package: types, constants and codes for the blit texture address generator.
`timescale 1ns / 1ps
`default_nettype none
package btag_pkg;

  localparam int MAX_DIM_DEF = 4096;

  localparam int OFF_W  = 12;
  localparam int ORG_W  = 12;
  localparam int SIZE_W = 13;
  localparam int MODE_W = 3;
  localparam int IDX_W  = 3;
  localparam int DATA_W = 13;
  localparam int NUM_W  = OFF_W + SIZE_W;
  localparam int REM_W  = SIZE_W + 1;
  localparam int LANES  = 2;

  localparam logic [MODE_W-1:0] MODE_NONE    = 3'd0;
  localparam logic [MODE_W-1:0] MODE_REPEAT  = 3'd1;
  localparam logic [MODE_W-1:0] MODE_CLAMP   = 3'd2;
  localparam logic [MODE_W-1:0] MODE_MIRROR  = 3'd3;
  localparam logic [MODE_W-1:0] MODE_STRETCH = 3'd4;

  localparam logic [IDX_W-1:0] REG_ADDRESS_MODE    = 3'd0;
  localparam logic [IDX_W-1:0] REG_SOURCE_ORIGIN_X = 3'd1;
  localparam logic [IDX_W-1:0] REG_SOURCE_ORIGIN_Y = 3'd2;
  localparam logic [IDX_W-1:0] REG_SOURCE_WIDTH    = 3'd3;
  localparam logic [IDX_W-1:0] REG_SOURCE_HEIGHT   = 3'd4;
  localparam logic [IDX_W-1:0] REG_DEST_WIDTH      = 3'd5;
  localparam logic [IDX_W-1:0] REG_DEST_HEIGHT     = 3'd6;

  typedef struct packed {
    logic [OFF_W-1:0] offset_x;
    logic [OFF_W-1:0] offset_y;
  } in_item_t;

  typedef struct packed {
    logic [SIZE_W-1:0] sample_x;
    logic [SIZE_W-1:0] sample_y;
    logic              sample_valid;
  } out_item_t;

  typedef struct packed {
    logic [MODE_W-1:0] address_mode;
    logic [ORG_W-1:0]  source_origin_x;
    logic [ORG_W-1:0]  source_origin_y;
    logic [SIZE_W-1:0] source_width;
    logic [SIZE_W-1:0] source_height;
    logic [SIZE_W-1:0] dest_width;
    logic [SIZE_W-1:0] dest_height;
  } cfg_t;

  typedef struct packed {
    logic [MODE_W-1:0] mode;
    logic [SIZE_W-1:0] s;
    logic [ORG_W-1:0]  org;
    logic [SIZE_W-1:0] ssize;
    logic              dzero;
  } axis_side_t;

  typedef struct packed {
    logic [REM_W-1:0] rem;
    logic [NUM_W-1:0] nq;
    logic [REM_W-1:0] den;
    axis_side_t       side;
  } div_lane_t;

endpackage
`default_nettype wire

// ----- rtl/btag_prep.sv -----
// First stage: sizes limited, sums, stretch product and divider operands.
`timescale 1ns / 1ps
`default_nettype none
module btag_prep #(
  parameter int MAX_DIM = btag_pkg::MAX_DIM_DEF
) (
  input  wire logic                             clk,
  input  wire logic                             rst,
  input  wire logic                             en,
  input  wire logic                             in_vld,
  input  wire btag_pkg::in_item_t               in_item,
  input  wire btag_pkg::cfg_t                   cfg,
  output logic                                  vld,
  output btag_pkg::div_lane_t [btag_pkg::LANES-1:0] lanes
);
  import btag_pkg::*;

  localparam int LIM_I = (MAX_DIM > (1 << SIZE_W) - 1) ? (1 << SIZE_W) - 1 : MAX_DIM;
  localparam logic [SIZE_W-1:0] LIM = SIZE_W'(LIM_I);

  function automatic logic [SIZE_W-1:0] limit(input logic [SIZE_W-1:0] v);
    return (v > LIM) ? LIM : v;
  endfunction

  function automatic div_lane_t build(input logic [MODE_W-1:0] mode,
                                      input logic [OFF_W-1:0] off,
                                      input logic [ORG_W-1:0] org,
                                      input logic [SIZE_W-1:0] ssize_raw,
                                      input logic [SIZE_W-1:0] dsize_raw);
    logic [SIZE_W-1:0] ss;
    logic [SIZE_W-1:0] ds;
    logic [SIZE_W-1:0] s;
    div_lane_t         l;
    ss = limit(ssize_raw);
    ds = limit(dsize_raw);
    s  = SIZE_W'(org) + SIZE_W'(off);
    l.rem        = '0;
    l.side.mode  = mode;
    l.side.s     = s;
    l.side.org   = org;
    l.side.ssize = ss;
    l.side.dzero = (ds == '0);
    case (mode)
      MODE_REPEAT: begin
        l.nq  = NUM_W'(s);
        l.den = REM_W'(ss);
      end
      MODE_MIRROR: begin
        l.nq  = NUM_W'(s);
        l.den = {ss, 1'b0};
      end
      MODE_STRETCH: begin
        l.nq  = NUM_W'(off) * NUM_W'(ss);
        l.den = REM_W'(ds);
      end
      default: begin
        l.nq  = NUM_W'(s);
        l.den = REM_W'(1);
      end
    endcase
    return l;
  endfunction

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= 1'b0;
    end else if (en) begin
      vld <= in_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      lanes[0] <= build(cfg.address_mode, in_item.offset_x, cfg.source_origin_x,
                        cfg.source_width, cfg.dest_width);
      lanes[1] <= build(cfg.address_mode, in_item.offset_y, cfg.source_origin_y,
                        cfg.source_height, cfg.dest_height);
    end
  end

endmodule
`default_nettype wire

// ----- rtl/btag_divider.sv -----
// Pipelined restoring divider, one quotient bit per stage, two lanes.
`timescale 1ns / 1ps
`default_nettype none
module btag_divider (
  input  wire logic                                 clk,
  input  wire logic                                 rst,
  input  wire logic                                 en,
  input  wire logic                                 in_vld,
  input  wire btag_pkg::div_lane_t [btag_pkg::LANES-1:0] in_lanes,
  output logic                                      out_vld,
  output btag_pkg::div_lane_t [btag_pkg::LANES-1:0] out_lanes
);
  import btag_pkg::*;

  function automatic div_lane_t step(input div_lane_t a);
    logic [REM_W:0]   trial;
    logic [REM_W:0]   diff;
    logic             q;
    div_lane_t        b;
    b     = a;
    trial = {a.rem, a.nq[NUM_W-1]};
    diff  = trial - {1'b0, a.den};
    q     = (trial >= {1'b0, a.den});
    b.rem = q ? diff[REM_W-1:0] : trial[REM_W-1:0];
    b.nq  = {a.nq[NUM_W-2:0], q};
    return b;
  endfunction

  div_lane_t [LANES-1:0] st [NUM_W];
  logic [NUM_W-1:0]      vld;

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (en) begin
      vld <= {vld[NUM_W-2:0], in_vld};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int j = 0; j < LANES; j++) begin
        st[0][j] <= step(in_lanes[j]);
        for (int k = 1; k < NUM_W; k++) begin
          st[k][j] <= step(st[k-1][j]);
        end
      end
    end
  end

  assign out_vld   = vld[NUM_W-1];
  assign out_lanes = st[NUM_W-1];

endmodule
`default_nettype wire

// ----- rtl/btag_post.sv -----
// Last stage: per-axis mode selection and output register.
`timescale 1ns / 1ps
`default_nettype none
module btag_post (
  input  wire logic                                 clk,
  input  wire logic                                 rst,
  input  wire logic                                 en,
  input  wire logic                                 in_vld,
  input  wire btag_pkg::div_lane_t [btag_pkg::LANES-1:0] in_lanes,
  output logic                                      out_vld,
  output btag_pkg::out_item_t                       out_item
);
  import btag_pkg::*;

  typedef struct packed {
    logic [SIZE_W-1:0] coord;
    logic              ok;
  } axis_res_t;

  function automatic axis_res_t finish(input div_lane_t l);
    logic [SIZE_W-1:0] q_rem;
    logic [REM_W-1:0]  fold;
    logic [NUM_W:0]    t;
    axis_res_t         r;
    q_rem = l.rem[SIZE_W-1:0];
    fold  = {l.side.ssize, 1'b0} - REM_W'(1) - l.rem;
    t     = {1'b0, l.nq} + (NUM_W + 1)'(l.side.org);
    r     = '0;
    if (l.side.ssize != '0) begin
      case (l.side.mode)
        MODE_NONE: begin
          r.coord = l.side.s;
          r.ok    = (l.side.s < l.side.ssize);
        end
        MODE_REPEAT: begin
          r.coord = q_rem;
          r.ok    = 1'b1;
        end
        MODE_CLAMP: begin
          r.coord = (l.side.s < l.side.ssize) ? l.side.s : l.side.ssize - SIZE_W'(1);
          r.ok    = 1'b1;
        end
        MODE_MIRROR: begin
          if (l.side.s < l.side.ssize) begin
            r.coord = l.side.s;
          end else if (l.rem < REM_W'(l.side.ssize)) begin
            r.coord = q_rem;
          end else begin
            r.coord = fold[SIZE_W-1:0];
          end
          r.ok = 1'b1;
        end
        MODE_STRETCH: begin
          if (!l.side.dzero) begin
            r.coord = t[SIZE_W-1:0];
            r.ok    = (t < (NUM_W + 1)'(l.side.ssize));
          end
        end
        default: begin
          r = '0;
        end
      endcase
    end
    return r;
  endfunction

  axis_res_t rx;
  axis_res_t ry;

  always_comb begin
    rx = finish(in_lanes[0]);
    ry = finish(in_lanes[1]);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_vld <= 1'b0;
    end else if (en) begin
      out_vld <= in_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      out_item.sample_x     <= rx.coord;
      out_item.sample_y     <= ry.coord;
      out_item.sample_valid <= rx.ok & ry.ok;
    end
  end

endmodule
`default_nettype wire

// ----- rtl/blit_texture_address_generator.sv -----
// Blit texture address generator: 27 register stages. One item per cycle
// sustained; the 25-stage divider (one quotient bit per stage) sets the depth,
// and a stalled output freezes the whole pipeline.
// Reset (rst, synchronous) empties the pipeline and loads register defaults:
// mode none, origins 0, all sizes 1.
`timescale 1ns / 1ps
`default_nettype none
module blit_texture_address_generator #(
  parameter int MAX_DIM = btag_pkg::MAX_DIM_DEF
) (
  input  wire logic                         clk,
  input  wire logic                         rst,
  input  wire logic                         cfg_wr_en,
  input  wire logic [btag_pkg::IDX_W-1:0]   cfg_index,
  input  wire logic [btag_pkg::DATA_W-1:0]  cfg_data,
  input  wire logic                         req_valid,
  output logic                              req_ready,
  input  wire btag_pkg::in_item_t           req,
  output logic                              rsp_valid,
  input  wire logic                         rsp_ready,
  output btag_pkg::out_item_t               rsp
);
  import btag_pkg::*;

  cfg_t                  cfg;
  logic                  en;
  logic                  prep_vld;
  div_lane_t [LANES-1:0] prep_lanes;
  logic                  div_vld;
  div_lane_t [LANES-1:0] div_lanes;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.address_mode    <= MODE_NONE;
      cfg.source_origin_x <= '0;
      cfg.source_origin_y <= '0;
      cfg.source_width    <= SIZE_W'(1);
      cfg.source_height   <= SIZE_W'(1);
      cfg.dest_width      <= SIZE_W'(1);
      cfg.dest_height     <= SIZE_W'(1);
    end else if (cfg_wr_en) begin
      case (cfg_index)
        REG_ADDRESS_MODE:    cfg.address_mode    <= cfg_data[MODE_W-1:0];
        REG_SOURCE_ORIGIN_X: cfg.source_origin_x <= cfg_data[ORG_W-1:0];
        REG_SOURCE_ORIGIN_Y: cfg.source_origin_y <= cfg_data[ORG_W-1:0];
        REG_SOURCE_WIDTH:    cfg.source_width    <= cfg_data[SIZE_W-1:0];
        REG_SOURCE_HEIGHT:   cfg.source_height   <= cfg_data[SIZE_W-1:0];
        REG_DEST_WIDTH:      cfg.dest_width      <= cfg_data[SIZE_W-1:0];
        REG_DEST_HEIGHT:     cfg.dest_height     <= cfg_data[SIZE_W-1:0];
        default: begin
        end
      endcase
    end
  end

  assign en        = !rsp_valid || rsp_ready;
  assign req_ready = en;

  btag_prep #(
    .MAX_DIM(MAX_DIM)
  ) u_prep (
    .clk     (clk),
    .rst     (rst),
    .en      (en),
    .in_vld  (req_valid),
    .in_item (req),
    .cfg     (cfg),
    .vld     (prep_vld),
    .lanes   (prep_lanes)
  );

  btag_divider u_div (
    .clk       (clk),
    .rst       (rst),
    .en        (en),
    .in_vld    (prep_vld),
    .in_lanes  (prep_lanes),
    .out_vld   (div_vld),
    .out_lanes (div_lanes)
  );

  btag_post u_post (
    .clk      (clk),
    .rst      (rst),
    .en       (en),
    .in_vld   (div_vld),
    .in_lanes (div_lanes),
    .out_vld  (rsp_valid),
    .out_item (rsp)
  );

  a_reset_empty: assert property (@(posedge clk) $past(rst) |-> !rsp_valid)
    else $error("result valid right after reset");

  a_rise_from_pipe: assert property (@(posedge clk) disable iff (rst)
    $rose(rsp_valid) |-> $past(div_vld))
    else $error("result appeared with no item leaving the divider");

  a_stall_freeze: assert property (@(posedge clk) disable iff (rst)
    (rsp_valid && !rsp_ready) |=> $stable(div_vld) && $stable(prep_vld))
    else $error("pipeline moved during output stall");

endmodule
`default_nettype wire
